@@ hw/rtl/mcf_pkg.sv @@
// shared types and constants of the mask correlation filter
package mcf_pkg;

    localparam int REQ_W      = 2;
    localparam int IDX_W      = 7;
    localparam int COEF_W     = 20;
    localparam int PIX_W      = 8;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int PIX_MAX    = 255;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PIXEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

    localparam logic [2:0] REG_MASK_ROWS     = 3'd0;
    localparam logic [2:0] REG_MASK_COLS     = 3'd1;
    localparam logic [2:0] REG_PIVOT_ROW     = 3'd2;
    localparam logic [2:0] REG_PIVOT_COL     = 3'd3;
    localparam logic [2:0] REG_RESULT_OFFSET = 3'd4;
    localparam logic [2:0] REG_NEGATIVE_MODE = 3'd5;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd6;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd7;

    typedef struct packed {
        logic [3:0]        mask_rows;
        logic [3:0]        mask_cols;
        logic [3:0]        pivot_row;
        logic [3:0]        pivot_col;
        logic signed [8:0] result_offset;
        logic              negative_mode;
        logic [10:0]       image_width;
        logic [10:0]       image_height;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic store;
        logic frame_reset;
        logic div_start;
        logic div_step;
        logic setup;
        logic tap_issue;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             pending;
        logic             px_ready;
        logic             div_last;
        logic             tap_last;
        logic             out_free;
    } sts_t;

endpackage

@@ hw/rtl/mcf_cfg_regs.sv @@
// configuration register bank behind the apb port
module mcf_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mcf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mcf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mcf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output mcf_pkg::cfg_t                    cfg
);
    import mcf_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mask_rows     <= 4'd3;
            cfg_reg.mask_cols     <= 4'd3;
            cfg_reg.pivot_row     <= 4'd1;
            cfg_reg.pivot_col     <= 4'd1;
            cfg_reg.result_offset <= 9'sd0;
            cfg_reg.negative_mode <= 1'b0;
            cfg_reg.image_width   <= 11'd1024;
            cfg_reg.image_height  <= 11'd1024;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MASK_ROWS:     cfg_reg.mask_rows     <= pwdata[3:0];
                REG_MASK_COLS:     cfg_reg.mask_cols     <= pwdata[3:0];
                REG_PIVOT_ROW:     cfg_reg.pivot_row     <= pwdata[3:0];
                REG_PIVOT_COL:     cfg_reg.pivot_col     <= pwdata[3:0];
                REG_RESULT_OFFSET: cfg_reg.result_offset <= $signed(pwdata[8:0]);
                REG_NEGATIVE_MODE: cfg_reg.negative_mode <= pwdata[0];
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= pwdata[10:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MASK_ROWS:     prdata = {28'b0, cfg_reg.mask_rows};
            REG_MASK_COLS:     prdata = {28'b0, cfg_reg.mask_cols};
            REG_PIVOT_ROW:     prdata = {28'b0, cfg_reg.pivot_row};
            REG_PIVOT_COL:     prdata = {28'b0, cfg_reg.pivot_col};
            REG_RESULT_OFFSET: prdata = {23'b0, cfg_reg.result_offset};
            REG_NEGATIVE_MODE: prdata = {31'b0, cfg_reg.negative_mode};
            REG_IMAGE_WIDTH:   prdata = {21'b0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT:  prdata = {21'b0, cfg_reg.image_height};
            default:           prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/mcf_ctrl.sv @@
// controller state machine sequencing requests through the datapath
module mcf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mcf_pkg::sts_t sts,
    output mcf_pkg::cmd_t cmd
);
    import mcf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_CHECK  = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_SETUP  = 4'd4;
    localparam logic [3:0] S_TAP    = 4'd5;
    localparam logic [3:0] S_DRAIN1 = 4'd6;
    localparam logic [3:0] S_DRAIN2 = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_IDLE;
                case (sts.req)
                    REQ_LOAD: cmd.load = 1'b1;
                    REQ_PIXEL: begin
                        if (!sts.full) begin
                            cmd.store  = 1'b1;
                            state_next = S_CHECK;
                        end
                    end
                    REQ_FLUSH: begin
                        if (sts.full && !sts.pending) begin
                            cmd.frame_reset = 1'b1;
                        end else if (sts.full) begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    default: ;
                endcase
            end
            S_CHECK: begin
                if (sts.pending && sts.px_ready) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = S_TAP;
            end
            S_TAP: begin
                cmd.tap_issue = 1'b1;
                if (sts.tap_last) begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1: state_next = S_DRAIN2;
            S_DRAIN2: state_next = S_FINISH;
            S_FINISH: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == S_DECIDE)
        else $error("request accepted but not decoded next cycle");

    a_setup_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SETUP |-> $past(state_reg) == S_DIV && $past(sts.div_last))
        else $error("tap setup entered before the divider finished");

    a_tap_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_TAP && !sts.tap_last |=> state_reg == S_TAP)
        else $error("tap loop left early");

    a_drain_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DRAIN1 |=> ##1 state_reg == S_FINISH)
        else $error("accumulator drain length wrong");

endmodule

@@ hw/rtl/mcf_datapath.sv @@
// datapath: line store, coefficient table, divider, tap mac and output register
module mcf_datapath #(
    parameter int MAX_MASK_DIM   = 11,
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mcf_pkg::cmd_t                   cmd,
    output mcf_pkg::sts_t                   sts,
    input  mcf_pkg::cfg_t                   cfg,
    input  logic [mcf_pkg::REQ_W-1:0]       s_tuser,
    input  logic [mcf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [mcf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import mcf_pkg::*;

    localparam int TABLE_DEPTH = MAX_MASK_DIM * MAX_MASK_DIM;
    localparam int TB    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MB    = $clog2(MAX_MASK_DIM + 1);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int PB    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DB    = $clog2(PB);
    localparam int AW    = $clog2(MAX_MASK_DIM * MAX_WIDTH);
    localparam int LS_DEPTH = 1 << AW;
    localparam int RW    = HB + 2;
    localparam int CW    = WB + 2;
    localparam int SPW   = PB + 2;
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(TABLE_DEPTH + 1) + 1;
    localparam int VW     = ACC_W + 2;

    // effective configuration
    logic [MB-1:0] mr_e, mc_e, pr_e, pc_e, dr, dc;
    logic [WB-1:0] w_e;
    logic [HB-1:0] h_e;

    always_comb begin
        if (cfg.mask_rows == 4'd0)                      mr_e = MB'(1);
        else if (int'(cfg.mask_rows) > MAX_MASK_DIM)    mr_e = MB'(MAX_MASK_DIM);
        else                                            mr_e = MB'(cfg.mask_rows);
        if (cfg.mask_cols == 4'd0)                      mc_e = MB'(1);
        else if (int'(cfg.mask_cols) > MAX_MASK_DIM)    mc_e = MB'(MAX_MASK_DIM);
        else                                            mc_e = MB'(cfg.mask_cols);
        if (int'(cfg.pivot_row) < int'(mr_e))           pr_e = MB'(cfg.pivot_row);
        else                                            pr_e = mr_e - MB'(1);
        if (int'(cfg.pivot_col) < int'(mc_e))           pc_e = MB'(cfg.pivot_col);
        else                                            pc_e = mc_e - MB'(1);
        if (cfg.image_width == 11'd0)                   w_e = WB'(1);
        else if (int'(cfg.image_width) > MAX_WIDTH)     w_e = WB'(MAX_WIDTH);
        else                                            w_e = WB'(cfg.image_width);
        if (cfg.image_height == 11'd0)                  h_e = HB'(1);
        else if (int'(cfg.image_height) > MAX_HEIGHT)   h_e = HB'(MAX_HEIGHT);
        else                                            h_e = HB'(cfg.image_height);
        dr = mr_e - MB'(1) - pr_e;
        dc = mc_e - MB'(1) - pc_e;
    end

    logic [WB+HB-1:0] tot_full;
    logic [MB+WB-1:0] dly_full;
    logic [PB-1:0]    total_reg;
    logic [PB:0]      delay_reg;

    assign tot_full = w_e * h_e;
    assign dly_full = dr * w_e;

    always_ff @(posedge aclk) begin
        total_reg <= tot_full[PB-1:0];
        delay_reg <= (PB+1)'(dly_full) + (PB+1)'(dc);
    end

    // latched request
    logic [REQ_W-1:0]         req_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic signed [COEF_W-1:0] coef_reg;
    logic [23:0]              pix_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg  <= s_tuser;
            idx_reg  <= s_tdata[6:0];
            coef_reg <= $signed(s_tdata[26:7]);
            pix_reg  <= {s_tdata[34:27], s_tdata[42:35], s_tdata[50:43]};
        end
    end

    // raster positions
    logic [PB-1:0]  in_pos_reg, out_pos_reg;
    logic [PB+1:0]  ready_sum;
    logic           out_last;

    assign ready_sum = {2'b00, out_pos_reg} + {1'b0, delay_reg};
    assign out_last  = ({1'b0, out_pos_reg} + (PB+1)'(1)) >= {1'b0, total_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
        end else if (cmd.frame_reset || (cmd.emit && out_last)) begin
            in_pos_reg  <= '0;
            out_pos_reg <= '0;
        end else if (cmd.emit) begin
            out_pos_reg <= out_pos_reg + PB'(1);
        end else if (cmd.store) begin
            in_pos_reg <= in_pos_reg + PB'(1);
        end
    end

    // coefficient table
    logic signed [COEF_W-1:0] coef_mem [TABLE_DEPTH];
    logic signed [COEF_W-1:0] cf_rd_reg;
    logic [TB-1:0]            cidx_reg;
    logic [TB-1:0]            load_addr;

    assign load_addr = TB'(idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load && (int'(idx_reg) < TABLE_DEPTH)) begin
            coef_mem[load_addr] <= coef_reg;
        end
        cf_rd_reg <= coef_mem[cidx_reg];
    end

    // line store ring, indexed by raster position modulo its depth
    logic [23:0]           ls_mem [LS_DEPTH];
    logic [23:0]           ls_rd_reg;
    logic signed [SPW-1:0] pos_reg, pos_row_reg;

    always_ff @(posedge aclk) begin
        if (cmd.store) begin
            ls_mem[in_pos_reg[AW-1:0]] <= pix_reg;
        end
        ls_rd_reg <= ls_mem[pos_reg[AW-1:0]];
    end

    // bit-serial divider: out_pos / width gives row and column
    logic [PB-1:0]    dvd_reg;
    logic [WB-1:0]    rem_reg;
    logic [DB-1:0]    div_cnt_reg;
    logic [MB+WB-1:0] prw_reg;
    logic [WB:0]      rem_sh, rem_sub;
    logic             rem_ge;

    assign rem_sh  = {rem_reg, dvd_reg[PB-1]};
    assign rem_ge  = rem_sh >= {1'b0, w_e};
    assign rem_sub = rem_sh - {1'b0, w_e};

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            dvd_reg     <= out_pos_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            prw_reg     <= pr_e * w_e;
        end else if (cmd.div_step) begin
            rem_reg     <= rem_ge ? rem_sub[WB-1:0] : rem_sh[WB-1:0];
            dvd_reg     <= {dvd_reg[PB-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DB'(1);
        end
    end

    // tap walk
    logic signed [RW-1:0] r_reg;
    logic signed [CW-1:0] c_reg, c0_reg;
    logic [MB-1:0]        k_reg, l_reg;
    logic                 tap_valid, row_end;
    logic signed [SPW-1:0] pos0, pos_next_row;

    assign pos0 = $signed({2'b00, out_pos_reg}) - $signed(SPW'(prw_reg))
                  - $signed(SPW'(pc_e));
    assign pos_next_row = pos_row_reg + $signed(SPW'(w_e));
    assign row_end = (l_reg == mc_e - MB'(1));
    assign tap_valid = !r_reg[RW-1] && !c_reg[CW-1]
                       && (r_reg < $signed({2'b00, h_e}))
                       && (c_reg < $signed({2'b00, w_e}))
                       && (pos_reg < $signed({2'b00, in_pos_reg}));

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            r_reg       <= $signed({2'b00, dvd_reg[HB-1:0]}) - $signed(RW'(pr_e));
            c0_reg      <= $signed({2'b00, rem_reg}) - $signed(CW'(pc_e));
            c_reg       <= $signed({2'b00, rem_reg}) - $signed(CW'(pc_e));
            pos_row_reg <= pos0;
            pos_reg     <= pos0;
            k_reg       <= '0;
            l_reg       <= '0;
            cidx_reg    <= '0;
        end else if (cmd.tap_issue) begin
            cidx_reg <= cidx_reg + TB'(1);
            if (row_end) begin
                l_reg       <= '0;
                k_reg       <= k_reg + MB'(1);
                r_reg       <= r_reg + RW'(1);
                c_reg       <= c0_reg;
                pos_row_reg <= pos_next_row;
                pos_reg     <= pos_next_row;
            end else begin
                l_reg   <= l_reg + MB'(1);
                c_reg   <= c_reg + CW'(1);
                pos_reg <= pos_reg + SPW'(1);
            end
        end
    end

    // mac pipeline: read, multiply, accumulate
    logic                      v1_reg;
    logic signed [PROD_W-1:0]  prod_r_reg, prod_g_reg, prod_b_reg;
    logic signed [ACC_W-1:0]   acc_r_reg, acc_g_reg, acc_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.tap_issue && tap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        // products kept signed so negative coefficients extend correctly
        if (v1_reg) begin
            prod_r_reg <= cf_rd_reg * $signed({1'b0, ls_rd_reg[23:16]});
            prod_g_reg <= cf_rd_reg * $signed({1'b0, ls_rd_reg[15:8]});
            prod_b_reg <= cf_rd_reg * $signed({1'b0, ls_rd_reg[7:0]});
        end else begin
            prod_r_reg <= '0;
            prod_g_reg <= '0;
            prod_b_reg <= '0;
        end
        if (cmd.setup) begin
            acc_r_reg <= '0;
            acc_g_reg <= '0;
            acc_b_reg <= '0;
        end else begin
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
            acc_g_reg <= acc_g_reg + ACC_W'(prod_g_reg);
            acc_b_reg <= acc_b_reg + ACC_W'(prod_b_reg);
        end
    end

    function automatic logic [7:0] chan_result(input logic signed [ACC_W-1:0] s,
                                               input logic mode,
                                               input logic signed [8:0] off);
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] q;
        a = VW'(s);
        if (a < 0) begin
            a = mode ? -a : '0;
        end
        v = a + (VW'(off) <<< COEF_FRAC_BITS);
        q = v >>> COEF_FRAC_BITS;
        if (v < 0) begin
            chan_result = 8'd0;
        end else if (q > VW'(PIX_MAX)) begin
            chan_result = 8'(PIX_MAX);
        end else begin
            chan_result = q[7:0];
        end
    endfunction

    // output register
    logic        m_valid_reg;
    logic [23:0] m_data_reg;
    logic        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg <= {chan_result(acc_b_reg, cfg.negative_mode, cfg.result_offset),
                           chan_result(acc_g_reg, cfg.negative_mode, cfg.result_offset),
                           chan_result(acc_r_reg, cfg.negative_mode, cfg.result_offset)};
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign sts.req      = req_reg;
    assign sts.full     = in_pos_reg >= total_reg;
    assign sts.pending  = out_pos_reg < total_reg;
    assign sts.px_ready = ready_sum < {2'b00, in_pos_reg};
    assign sts.div_last = (div_cnt_reg == DB'(PB - 1));
    assign sts.tap_last = (k_reg == mr_e - MB'(1)) && row_end;
    assign sts.out_free = !m_valid_reg || m_tready;

endmodule

@@ hw/rtl/mask_correlation_filter.sv @@
// top level of the zero-padded rgb mask correlation filter
//
//  channel  | direction | handshake               | payload
//  s_       | in        | s_tvalid / s_tready     | s_tuser request kind, s_tdata load/pixel
//  m_       | out       | m_tvalid / m_tready     | m_tdata filtered pixel, m_tlast frame end
//  apb      | in/out    | psel, penable, pready   | register write and read
//
// a load or a pixel without result needs neither divider nor mac; a request that yields a
// pixel runs the bit-serial position divider over the raster count width (21 bits at
// default size), then the shared tap mac, which takes one tap per cycle, over every
// mask tap, and drains the mac before the result is emitted.
// reset is synchronous active low; line store and coefficient table are not cleared.
// a result sits in the output register while the next request is accepted; a later
// result waits in the controller until that register is free.
module mask_correlation_filter #(
    parameter int MAX_MASK_DIM   = 11,
    parameter int MAX_WIDTH      = 1024,
    parameter int MAX_HEIGHT     = 1024,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] req_type
    input  logic [mcf_pkg::REQ_W-1:0]        s_tuser,
    // [6:0] coef_index, [26:7] coef_value, [34:27] red_in, [42:35] green_in,
    // [50:43] blue_in, [55:51] zero
    input  logic [mcf_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic [mcf_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mcf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mcf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mcf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import mcf_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    mcf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcf_datapath #(
        .MAX_MASK_DIM   (MAX_MASK_DIM),
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ bench/tb_mask_correlation_filter.sv @@
// self-checking bench for the mask correlation filter: streamed frames against a predictor
`timescale 1ns / 100ps

module tb_mask_correlation_filter;
    import mcf_pkg::*;

    localparam int TABLE_N  = 121;
    localparam int FRAME_N  = 1024 * 1024;
    localparam int SETTLE   = 300;
    localparam int WD_LIMIT = 5000;
    localparam int HOLD_LEN = 800;

    // request kind with no meaning, must be ignored
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [IDX_W-1:0]  idx;
        logic [COEF_W-1:0] coef;
        logic [PIX_W-1:0]  red, green, blue;
    } request_t;

    typedef struct {
        logic [PIX_W-1:0] red, green, blue;
        logic             last;
    } pixel_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0, m_tready = 1'b0;
    logic [REQ_W-1:0] s_tuser = '0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tready, m_tvalid, m_tlast, pready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;

    request_t   request_queue[$];
    pixel_out_t expected_pixels[$];
    int send_idle = 0, recv_idle = 0;
    int hold_go = 0, hold_seen = 0, hold_cnt = 0;
    int errors = 0, quiet_cycles = 0;

    // predictor state
    logic [3:0]        cf_rows = 3, cf_cols = 3, cf_prow = 1, cf_pcol = 1;
    logic signed [8:0] cf_offset = 0;
    logic              cf_neg = 0;
    logic [10:0]       cf_width = 1024, cf_height = 1024;
    int                coef_table[TABLE_N];
    logic [23:0]       frame_store[FRAME_N];
    int                in_pos = 0, out_pos = 0;

    mask_correlation_filter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 aclk = ~aclk;

    function automatic void queue_request(request_t rq);
        request_queue = {request_queue, rq};
    endfunction

    function automatic int eff_w();
        return cf_width == 0 ? 1 : (cf_width > 1024 ? 1024 : int'(cf_width));
    endfunction
    function automatic int eff_h();
        return cf_height == 0 ? 1 : (cf_height > 1024 ? 1024 : int'(cf_height));
    endfunction
    function automatic int eff_rows();
        return cf_rows == 0 ? 1 : (cf_rows > 11 ? 11 : int'(cf_rows));
    endfunction
    function automatic int eff_cols();
        return cf_cols == 0 ? 1 : (cf_cols > 11 ? 11 : int'(cf_cols));
    endfunction
    function automatic int eff_prow();
        return cf_prow < eff_rows() ? int'(cf_prow) : eff_rows() - 1;
    endfunction
    function automatic int eff_pcol();
        return cf_pcol < eff_cols() ? int'(cf_pcol) : eff_cols() - 1;
    endfunction
    function automatic int raster_delay();
        return (eff_rows() - 1 - eff_prow()) * eff_w() + (eff_cols() - 1 - eff_pcol());
    endfunction

    function automatic logic [7:0] finish_channel(longint acc);
        longint v;
        if (acc < 0)
            acc = cf_neg ? -acc : 0;
        v = acc + longint'(cf_offset) * 4096;
        if (v < 0)
            return 8'd0;
        v = v >>> 12;
        return v > PIX_MAX ? 8'd255 : v[7:0];
    endfunction

    function automatic void filter_pixel();
        pixel_out_t px;
        int w, h, row, col, r, c, pos, cf;
        longint sr, sg, sb;
        w = eff_w();
        h = eff_h();
        row = out_pos / w;
        col = out_pos % w;
        sr = 0; sg = 0; sb = 0;
        for (int k = 0; k < eff_rows(); k++) begin
            for (int l = 0; l < eff_cols(); l++) begin
                r = row + k - eff_prow();
                c = col + l - eff_pcol();
                if (r >= 0 && c >= 0 && r < h && c < w) begin
                    pos = r * w + c;
                    if (pos < in_pos) begin
                        cf = coef_table[k * eff_cols() + l];
                        sr += longint'(cf) * frame_store[pos][23:16];
                        sg += longint'(cf) * frame_store[pos][15:8];
                        sb += longint'(cf) * frame_store[pos][7:0];
                    end
                end
            end
        end
        px.red = finish_channel(sr);
        px.green = finish_channel(sg);
        px.blue = finish_channel(sb);
        out_pos++;
        px.last = out_pos >= w * h;
        if (px.last) begin
            out_pos = 0;
            in_pos = 0;
        end
        expected_pixels = {expected_pixels, px};
    endfunction

    function automatic void predict_request(logic [REQ_W-1:0] kind, logic [S_TDATA_W-1:0] d);
        int total;
        total = eff_w() * eff_h();
        case (kind)
            REQ_LOAD: begin
                if (d[6:0] < TABLE_N)
                    coef_table[d[6:0]] = int'(signed'(d[26:7]));
            end
            REQ_PIXEL: begin
                if (in_pos < total) begin
                    frame_store[in_pos] = {d[34:27], d[42:35], d[50:43]};
                    in_pos++;
                    if (out_pos < total && out_pos + raster_delay() < in_pos)
                        filter_pixel();
                end
            end
            REQ_FLUSH: begin
                if (in_pos >= total) begin
                    if (out_pos >= total) begin
                        out_pos = 0;
                        in_pos = 0;
                    end else begin
                        filter_pixel();
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        request_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (request_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
                rq = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= rq.kind;
                s_tdata <= {5'd0, rq.blue, rq.green, rq.red, rq.coef, rq.idx};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_cnt <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && $urandom_range(99) >= recv_idle;
        end
    end

    // predictor and result check
    always @(posedge aclk) begin
        pixel_out_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel %h last %b", $time, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== {want.blue, want.green, want.red} || m_tlast !== want.last) begin
                        $display("%0t: expected %h last %b, got %h last %b", $time,
                                 {want.blue, want.green, want.red}, want.last, m_tdata, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MASK_ROWS:     cf_rows = value[3:0];
            REG_MASK_COLS:     cf_cols = value[3:0];
            REG_PIVOT_ROW:     cf_prow = value[3:0];
            REG_PIVOT_COL:     cf_pcol = value[3:0];
            REG_RESULT_OFFSET: cf_offset = value[8:0];
            REG_NEGATIVE_MODE: cf_neg = value[0];
            REG_IMAGE_WIDTH:   cf_width = value[10:0];
            default:           cf_height = value[10:0];
        endcase
    endtask

    task automatic configure(int rows, int cols, int prow, int pcol, int offset, int neg,
                             int w, int h);
        write_reg(REG_MASK_ROWS, rows);
        write_reg(REG_MASK_COLS, cols);
        write_reg(REG_PIVOT_ROW, prow);
        write_reg(REG_PIVOT_COL, pcol);
        write_reg(REG_RESULT_OFFSET, offset & 32'h1ff);
        write_reg(REG_NEGATIVE_MODE, neg);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic request_t make_request(logic [REQ_W-1:0] kind);
        request_t rq;
        rq.kind = kind;
        rq.idx = IDX_W'($urandom);
        rq.coef = COEF_W'($urandom);
        rq.red = PIX_W'($urandom);
        rq.green = PIX_W'($urandom);
        rq.blue = PIX_W'($urandom);
        return rq;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        if ($urandom_range(7) == 0)
            return COEF_W'($urandom);
        return COEF_W'($urandom_range(16383) - 8192);
    endfunction

    // coefficients in use, then one ignored load beyond the table
    function automatic void queue_coefs();
        request_t rq;
        for (int i = 0; i < eff_rows() * eff_cols(); i++) begin
            rq = make_request(REQ_LOAD);
            rq.idx = IDX_W'(i);
            rq.coef = pick_coef();
            queue_request(rq);
        end
        rq = make_request(REQ_LOAD);
        rq.idx = IDX_W'($urandom_range(127, TABLE_N));
        queue_request(rq);
    endfunction

    function automatic void queue_frame(bit noisy);
        request_t rq;
        int total, tail;
        total = eff_w() * eff_h();
        tail = raster_delay() < total ? raster_delay() : total;
        for (int p = 0; p < total; p++) begin
            if (noisy && $urandom_range(15) == 0)
                queue_request(make_request($urandom_range(3) == 0 ? REQ_SPARE : REQ_FLUSH));
            queue_request(make_request(REQ_PIXEL));
        end
        // a stray pixel while outputs are still pending is dropped
        if (noisy && tail > 0 && $urandom_range(1))
            queue_request(make_request(REQ_PIXEL));
        for (int f = 0; f < tail; f++)
            queue_request(make_request(REQ_FLUSH));
    endfunction

    task automatic drain();
        wait (request_queue.size() == 0 && !s_tvalid && expected_pixels.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        request_t rq;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle = 26;
        recv_idle = 58;

        // directed: extreme coefficients and pixels, unused kind, early flush
        configure(3, 3, 1, 1, 0, 0, 4, 3);
        for (int i = 0; i < 9; i++) begin
            rq = make_request(REQ_LOAD);
            rq.idx = IDX_W'(i);
            rq.coef = (i % 3 == 0) ? 20'h80000 : (i % 3 == 1 ? 20'h7ffff : 20'h01000);
            queue_request(rq);
        end
        rq = make_request(REQ_SPARE);
        queue_request(rq);
        rq = make_request(REQ_LOAD);
        rq.idx = 7'h7f;
        queue_request(rq);
        queue_request(make_request(REQ_FLUSH));
        for (int p = 0; p < 12; p++) begin
            rq = make_request(REQ_PIXEL);
            rq.red = p[0] ? 8'hff : 8'h00;
            rq.green = p[1] ? 8'hff : 8'h00;
            rq.blue = 8'hff - rq.red;
            queue_request(rq);
        end
        for (int f = 0; f < 5; f++)
            queue_request(make_request(REQ_FLUSH));
        drain();

        // fixed corner settings, then random small ones
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 4) begin
                send_idle = 58;
                recv_idle = 26;
            end else if (ph == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (ph)
                0: configure(11, 11, 10, 10, -255, 1, 5, 4);
                1: configure(1, 1, 0, 0, 255, 0, 1, 1);
                2: configure(0, 15, 15, 0, 17, 1, 13, 1);
                3: configure(5, 2, 2, 0, -3, 1, 5, 4);
                4: configure(2, 4, 0, 3, 100, 0, 0, 3);
                5: configure(4, 3, 3, 2, -40, 1, 6, 5);
                default: configure($urandom_range(1, 5), $urandom_range(1, 5),
                                   $urandom_range(0, 4), $urandom_range(0, 4),
                                   $urandom_range(0, 510) - 255, $urandom_range(1),
                                   $urandom_range(1, 9), $urandom_range(1, 6));
            endcase
            queue_coefs();
            for (int fr = 0; fr < (ph == 2 ? 1 : 2); fr++)
                queue_frame(fr == 1);
            if (ph == 5)
                hold_go++;
            drain();
        end

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
